FILE: rtl/button_long_press_repeat_unit_assert.svh
// assertion macros used by the checker file
`ifndef BUTTON_LONG_PRESS_REPEAT_UNIT_ASSERT_SVH
`define BUTTON_LONG_PRESS_REPEAT_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define BLPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("blpr assertion failed");

// next-cycle implication, disabled while reset is held
`define BLPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("blpr assertion failed");

`endif

FILE: rtl/blpr_pkg.sv
package blpr_pkg;

    // event codes on the result channel
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_LONG    = 2'd3
    } t_event;

    // button mode
    typedef enum logic [1:0] {
        MODE_UNDEF    = 2'd0,
        MODE_PRESSED  = 2'd1,
        MODE_RELEASED = 2'd2,
        MODE_LONG     = 2'd3
    } t_mode;

    // configuration register indexes
    typedef enum logic {
        CFG_LONG_PRESS = 1'b0,
        CFG_REPEAT     = 1'b1
    } t_cfg_idx;

    localparam int unsigned TICK_W   = 32;
    localparam int unsigned REPEAT_W = 8;

    localparam logic [TICK_W-1:0]   LONG_PRESS_RESET = 32'd1000;
    localparam logic [TICK_W-1:0]   REPEAT_RESET     = 32'd250;
    localparam logic [REPEAT_W-1:0] REPEAT_MAX       = 8'd255;

    // state carried from one poll to the next
    typedef struct packed {
        t_mode               mode;
        logic                prev_level;
        logic [TICK_W-1:0]   event_time;
        logic [REPEAT_W-1:0] repeat_count;
    } t_blpr_state;

    // result of one poll
    typedef struct packed {
        t_event              event_kind;
        logic [REPEAT_W-1:0] repeat_index;
        t_mode               mode_now;
    } t_blpr_result;

endpackage

FILE: rtl/blpr_step.sv
module blpr_step
    import blpr_pkg::*;
(
    input  t_blpr_state         i_state,
    input  logic [TICK_W-1:0]   i_tick_now,
    input  logic                i_level,
    input  logic [TICK_W-1:0]   i_long_press_ticks,
    input  logic [TICK_W-1:0]   i_repeat_ticks,
    output t_blpr_state         o_state,
    output t_blpr_result        o_result
);

    logic [TICK_W-1:0] elapsed;
    t_event            ev;
    logic [REPEAT_W-1:0] rep;
    t_blpr_state       nxt;

    // ticks since the last stamped event, modulo 2^32
    assign elapsed = i_tick_now - i_state.event_time;

    // edges first, then the timing checks of the current mode
    always_comb begin
        nxt            = i_state;
        nxt.prev_level = i_level;
        ev             = EV_NONE;
        rep            = '0;
        priority if (i_level && !i_state.prev_level) begin
            nxt.mode       = MODE_PRESSED;
            nxt.event_time = i_tick_now;
            ev             = EV_PRESS;
        end else if (!i_level && i_state.prev_level) begin
            nxt.mode = MODE_RELEASED;
            ev       = EV_RELEASE;
        end else if (i_state.mode == MODE_PRESSED) begin
            if (elapsed >= i_long_press_ticks) begin
                nxt.mode         = MODE_LONG;
                nxt.repeat_count = '0;
                nxt.event_time   = i_tick_now;
                ev               = EV_LONG;
            end
        end else if (i_state.mode == MODE_LONG) begin
            if (elapsed >= i_repeat_ticks) begin
                if (i_state.repeat_count != REPEAT_MAX) begin
                    nxt.repeat_count = i_state.repeat_count + 1'b1;
                end
                nxt.event_time = i_tick_now;
                ev             = EV_LONG;
                rep            = nxt.repeat_count;
            end
        end else begin
            // undefined or released mode with a steady level: no event
        end
    end

    assign o_state               = nxt;
    assign o_result.event_kind   = ev;
    assign o_result.repeat_index = rep;
    assign o_result.mode_now     = nxt.mode;

endmodule

FILE: rtl/button_long_press_repeat_unit.sv
// channel   direction  handshake                 payload
// in        to block   i_in_valid / o_in_stall   i_tick_now, i_level
// out       from block o_out_valid / i_out_stall o_event_kind, o_repeat_index, o_mode_now
// cfg       to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one transaction per cycle while no stall holds; a poll's result passes through
// the input register, then the mode update into the result register
// reset is synchronous and active low; it clears mode, level, time stamp and count
// while the result is stalled one more poll waits in the input register
// configuration is always ready and takes effect on the next evaluated poll
module button_long_press_repeat_unit
    import blpr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [TICK_W-1:0]   i_tick_now,
    input  logic                i_level,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_event_kind,
    output logic [REPEAT_W-1:0] o_repeat_index,
    output logic [1:0]          o_mode_now,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [TICK_W-1:0]   i_cfg_data
);

    logic [TICK_W-1:0] r_long_press_ticks;
    logic [TICK_W-1:0] r_repeat_ticks;
    logic              r_in_valid;
    logic [TICK_W-1:0] r_in_tick;
    logic              r_in_level;
    logic              r_out_valid;
    t_blpr_result      r_result;
    t_blpr_state       r_state;
    t_blpr_state       n_state;
    t_blpr_result      n_result;
    logic              out_free;
    logic              in_take;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ticks <= LONG_PRESS_RESET;
            r_repeat_ticks     <= REPEAT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LONG_PRESS: r_long_press_ticks <= i_cfg_data;
                CFG_REPEAT:     r_repeat_ticks     <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // handshake between the two register stages
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (out_free) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_tick  <= i_tick_now;
            r_in_level <= i_level;
        end
    end

    // per-poll decision logic
    blpr_step u_step (
        .i_state            (r_state),
        .i_tick_now         (r_in_tick),
        .i_level            (r_in_level),
        .i_long_press_ticks (r_long_press_ticks),
        .i_repeat_ticks     (r_repeat_ticks),
        .o_state            (n_state),
        .o_result           (n_result)
    );

    // button state advances as the poll moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode         <= MODE_UNDEF;
            r_state.prev_level   <= 1'b0;
            r_state.event_time   <= '0;
            r_state.repeat_count <= '0;
            r_out_valid          <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_kind   = r_result.event_kind;
    assign o_repeat_index = r_result.repeat_index;
    assign o_mode_now     = r_result.mode_now;

endmodule

FILE: rtl/blpr_checker.sv
`include "button_long_press_repeat_unit_assert.svh"

module blpr_props
    import blpr_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [1:0]          o_event_kind,
    input logic [REPEAT_W-1:0] o_repeat_index,
    input logic [1:0]          o_mode_now
);

    // a repeat number only comes with a long-press event
    `BLPR_ASSERT_NOW(a_rep_only_long, i_clk, i_rst_n,
        o_out_valid && (o_repeat_index != '0), o_event_kind == EV_LONG)

    // press and release events leave the matching mode
    `BLPR_ASSERT_NOW(a_press_mode, i_clk, i_rst_n,
        o_out_valid && (o_event_kind == EV_PRESS), o_mode_now == MODE_PRESSED)
    `BLPR_ASSERT_NOW(a_release_mode, i_clk, i_rst_n,
        o_out_valid && (o_event_kind == EV_RELEASE), o_mode_now == MODE_RELEASED)

    // long-press events leave the long-pressed mode
    `BLPR_ASSERT_NOW(a_long_mode, i_clk, i_rst_n,
        o_out_valid && (o_event_kind == EV_LONG), o_mode_now == MODE_LONG)

    // a stalled result transaction holds
    `BLPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_event_kind) && $stable(o_repeat_index)
        && $stable(o_mode_now))

endmodule

bind button_long_press_repeat_unit blpr_props u_blpr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_event_kind   (o_event_kind),
    .o_repeat_index (o_repeat_index),
    .o_mode_now     (o_mode_now)
);
